FILE: design/upwind_advection_flux_top_assert.svh
// Assertion macros used by the upwind advection flux port checker.
`ifndef UPWIND_ADVECTION_FLUX_TOP_ASSERT_SVH
`define UPWIND_ADVECTION_FLUX_TOP_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define UAF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("upwind flux assertion failed");

// Assertion that is checked during reset as well.
`define UAF_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("upwind flux reset assertion failed");

`endif

FILE: design/uaf_pkg.sv
// Package with constants, codes and control types of the upwind advection flux block.
`default_nettype none
package uaf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FLUX_W    = 48;
   localparam int PROD_W    = 66;

   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   localparam logic [1:0] EDGE_FIRST = 2'd0;
   localparam logic [1:0] EDGE_LAST  = 2'd2;
   localparam logic [1:0] EDGE_SKIP  = 2'd3;

   localparam logic [1:0] REG_VELOCITY_X = 2'd0;
   localparam logic [1:0] REG_VELOCITY_Y = 2'd1;
   localparam logic [1:0] REG_HUGE_STEP  = 2'd2;
   localparam logic [1:0] REG_MAX_STEP   = 2'd3;

   typedef enum logic [1:0] {
      MUL_VX_NX,
      MUL_VY_NY,
      MUL_UP_NV,
      MUL_EF_LEN
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        psum_en;
      logic        nv_en;
      logic        ef_en;
      logic        acc_en;
      logic        div_start;
      logic        div_flux;
      logic        step_en;
      logic        result_en;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_ratio;
      logic last_edge;
   } stat_type;

endpackage
`default_nettype wire

FILE: design/upwind_advection_flux_top.sv
// Top level of the upwind advection flux block: channels, registers and output stage.
//
// Requests carry one triangle edge each; an edge index of three is taken and dropped.
// Edges 0 and 1 only update the cell state; edge 2 yields one result with the cell
// update (flux over area) and the running pass timestep.
// A request also runs the ratio division when the cell is full and the normal speed
// is not zero; edge 2 adds the area division plus the output load.
// Both divisions go through one shared 32-step restoring divider, which sets the rate.
// The block holds one request at a time; req_tready is high only while it is idle.
// The result sits in an output register until rsp_tready takes it; a stalled
// receiver holds the last request in its output step and blocks new ones.
// Reset is synchronous: it clears the controller, the flux sum and cell step, loads
// the pass timestep and both step registers with the maximum and zeroes the velocity.
// The user must write registers over the csr_ port only while the block is idle; the block does not enforce it.
`default_nettype none
module upwind_advection_flux_top #(
   parameter int FRAC_BITS = uaf_pkg::FRAC_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // near_value, far_value, normal_x, normal_y, edge_length, cell_area, cell_radius
   input  wire logic [199:0] req_tdata,
   // edge_index, first_of_pass, full_cell
   input  wire logic [3:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // cell_update, pass_timestep
   output logic [63:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic signed [31:0] vx_ff, vy_ff;
   logic [30:0]        huge_ff, max_ff;
   logic               csr_wr;

   uaf_pkg::cmd_type  cmd;
   uaf_pkg::stat_type stat;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic signed [31:0] cell_update;
   logic [30:0]        pass_timestep;
   logic               out_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff   <= '0;
         vy_ff   <= '0;
         huge_ff <= uaf_pkg::MAX31;
         max_ff  <= uaf_pkg::MAX31;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            uaf_pkg::REG_VELOCITY_X: vx_ff   <= csr_pwdata;
            uaf_pkg::REG_VELOCITY_Y: vy_ff   <= csr_pwdata;
            uaf_pkg::REG_HUGE_STEP:  huge_ff <= csr_pwdata[30:0];
            default:                 max_ff  <= csr_pwdata[30:0];
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         uaf_pkg::REG_VELOCITY_X: csr_prdata = vx_ff;
         uaf_pkg::REG_VELOCITY_Y: csr_prdata = vy_ff;
         uaf_pkg::REG_HUGE_STEP:  csr_prdata = {1'b0, huge_ff};
         default:                 csr_prdata = {1'b0, max_ff};
      endcase
   end

   uaf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_edge   (req_tuser[1:0]),
      .out_free   (out_free),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   uaf_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .velocity_x    (vx_ff),
      .velocity_y    (vy_ff),
      .huge_step     (huge_ff),
      .max_step      (max_ff),
      .edge_index    (req_tuser[1:0]),
      .first_of_pass (req_tuser[2]),
      .near_value    (req_tdata[31:0]),
      .far_value     (req_tdata[63:32]),
      .normal_x      (req_tdata[81:64]),
      .normal_y      (req_tdata[99:82]),
      .edge_length   (req_tdata[130:100]),
      .cell_area     (req_tdata[161:131]),
      .cell_radius   (req_tdata[192:162]),
      .full_cell     (req_tuser[3]),
      .cell_update   (cell_update),
      .pass_timestep (pass_timestep)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, pass_timestep, cell_update};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: design/uaf_div.sv
// Iterative restoring divider with overflow flag for quotients that do not fit in 32 bits.
`default_nettype none
module uaf_div #(
   parameter int DVW = 64
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [DVW-1:0] dividend,
   input  wire logic [31:0]    divisor,
   output logic                done,
   output logic [31:0]         quotient,
   output logic                ovf
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic        ovf_ff, ovf_in;

   logic [DVW-33:0] hi;
   logic [32:0]     trial;
   logic            ge;

   always_comb begin
      hi      = dividend[DVW-1:32];
      trial   = {rem_ff, quo_ff[31]};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         if (hi >= (DVW-32)'(divisor)) begin
            ovf_in  = 1'b1;
            done_in = 1'b1;
            quo_in  = '0;
         end else begin
            ovf_in  = 1'b0;
            busy_in = 1'b1;
            cnt_in  = 6'd32;
            rem_in  = hi[31:0];
            quo_in  = dividend[31:0];
         end
      end else if (busy_ff) begin
         trial  = ge ? (trial - {1'b0, divisor}) : trial;
         rem_in = trial[31:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign ovf      = ovf_ff;

endmodule
`default_nettype wire

FILE: design/uaf_dp.sv
// Datapath: shared multiplier, flux accumulator, timestep minimums and divider.
`default_nettype none
module uaf_dp #(
   parameter int FRAC_BITS = uaf_pkg::FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire uaf_pkg::cmd_type   cmd,
   output uaf_pkg::stat_type       stat,
   input  wire logic signed [31:0] velocity_x,
   input  wire logic signed [31:0] velocity_y,
   input  wire logic [30:0]        huge_step,
   input  wire logic [30:0]        max_step,
   input  wire logic [1:0]         edge_index,
   input  wire logic               first_of_pass,
   input  wire logic signed [31:0] near_value,
   input  wire logic signed [31:0] far_value,
   input  wire logic signed [17:0] normal_x,
   input  wire logic signed [17:0] normal_y,
   input  wire logic [30:0]        edge_length,
   input  wire logic [30:0]        cell_area,
   input  wire logic [30:0]        cell_radius,
   input  wire logic               full_cell,
   output logic signed [31:0]      cell_update,
   output logic [30:0]             pass_timestep
);

   localparam int PW  = uaf_pkg::PROD_W;
   localparam int FW  = uaf_pkg::FLUX_W;
   localparam int DVW = FW + FRAC_BITS;

   localparam logic signed [PW-1:0] MAX32W = PW'(64'sh7FFF_FFFF);
   localparam logic signed [PW-1:0] MIN32W = -PW'(64'sh8000_0000);
   localparam logic signed [PW-1:0] MAX48W = PW'(64'sh7FFF_FFFF_FFFF);
   localparam logic signed [PW-1:0] MIN48W = -PW'(64'sh8000_0000_0000);

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
      logic signed [31:0] r;
      if (x > MAX32W) r = 32'sh7FFF_FFFF;
      else if (x < MIN32W) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   logic [1:0]         edge_ff;
   logic               first_ff;
   logic signed [31:0] near_ff, far_ff;
   logic signed [17:0] nx_ff, ny_ff;
   logic [30:0]        len_ff, area_ff, radius_ff;
   logic               full_ff;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] psum_ff, psum_in;
   logic signed [31:0]   nv_ff, nv_in;
   logic signed [31:0]   ef_ff, ef_in;
   logic signed [FW-1:0] flux_ff, flux_in;
   logic [30:0]          cell_ff, cell_in;
   logic [30:0]          global_ff, global_in;
   logic signed [31:0]   update_ff, update_in;

   logic signed [32:0]   mul_a, mul_b;
   logic signed [PW-1:0] sum, diff;
   logic [31:0]          speed;
   logic [FW-1:0]        mag;
   logic [DVW-1:0]       dividend;
   logic [31:0]          divisor;
   logic                 div_done, div_ovf;
   logic [31:0]          quo;
   logic [30:0]          ratio;

   always_comb begin
      case (cmd.mul_sel)
         uaf_pkg::MUL_VX_NX: begin
            mul_a = 33'(velocity_x);
            mul_b = 33'(nx_ff);
         end
         uaf_pkg::MUL_VY_NY: begin
            mul_a = 33'(velocity_y);
            mul_b = 33'(ny_ff);
         end
         uaf_pkg::MUL_UP_NV: begin
            mul_a = nv_ff[31] ? 33'(far_ff) : 33'(near_ff);
            mul_b = 33'(nv_ff);
         end
         default: begin
            mul_a = 33'(ef_ff);
            mul_b = $signed({2'b00, len_ff});
         end
      endcase
   end

   always_comb begin
      sum      = psum_ff + prod_ff;
      diff     = PW'(flux_ff) - (prod_ff >>> FRAC_BITS);
      speed    = nv_ff[31] ? (~nv_ff + 32'd1) : nv_ff;
      mag      = flux_ff[FW-1] ? (~flux_ff + FW'(1)) : flux_ff;
      dividend = cmd.div_flux ? {mag, {FRAC_BITS{1'b0}}}
                              : DVW'({radius_ff, {FRAC_BITS{1'b0}}});
      divisor  = cmd.div_flux ? {1'b0, area_ff} : speed;
      ratio    = (div_ovf || quo > {1'b0, uaf_pkg::MAX31}) ? uaf_pkg::MAX31 : quo[30:0];
   end

   uaf_div #(
      .DVW (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo),
      .ovf      (div_ovf)
   );

   always_comb begin
      prod_in   = cmd.mul_en ? (mul_a * mul_b) : prod_ff;
      psum_in   = cmd.psum_en ? prod_ff : psum_ff;
      nv_in     = cmd.nv_en ? sat32(sum >>> FRAC_BITS) : nv_ff;
      ef_in     = cmd.ef_en ? sat32(prod_ff >>> FRAC_BITS) : ef_ff;
      flux_in   = flux_ff;
      cell_in   = cell_ff;
      global_in = global_ff;
      update_in = update_ff;
      if (cmd.capture) begin
         if (first_of_pass) global_in = max_step;
         if (edge_index == uaf_pkg::EDGE_FIRST) begin
            flux_in = '0;
            cell_in = huge_step;
         end
      end
      if (cmd.acc_en) begin
         if (diff > MAX48W) flux_in = MAX48W[FW-1:0];
         else if (diff < MIN48W) flux_in = MIN48W[FW-1:0];
         else flux_in = diff[FW-1:0];
      end
      if (cmd.step_en && ratio < cell_ff) cell_in = ratio;
      if (cmd.result_en) begin
         if (mag == '0) update_in = '0;
         else if (!flux_ff[FW-1]) update_in = (div_ovf || quo[31]) ? 32'sh7FFF_FFFF : quo;
         else if (div_ovf || quo > 32'h8000_0000) update_in = 32'sh8000_0000;
         else update_in = -quo;
         if (cell_ff < global_ff) global_in = cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flux_ff   <= '0;
         cell_ff   <= '0;
         global_ff <= uaf_pkg::MAX31;
      end else begin
         flux_ff   <= flux_in;
         cell_ff   <= cell_in;
         global_ff <= global_in;
      end
      if (cmd.capture) begin
         edge_ff   <= edge_index;
         first_ff  <= first_of_pass;
         near_ff   <= near_value;
         far_ff    <= far_value;
         nx_ff     <= normal_x;
         ny_ff     <= normal_y;
         len_ff    <= edge_length;
         area_ff   <= cell_area;
         radius_ff <= cell_radius;
         full_ff   <= full_cell;
      end
      prod_ff   <= prod_in;
      psum_ff   <= psum_in;
      nv_ff     <= nv_in;
      ef_ff     <= ef_in;
      update_ff <= update_in;
   end

   assign stat.div_done   = div_done;
   assign stat.need_ratio = full_ff && (nv_ff != '0);
   assign stat.last_edge  = (edge_ff == uaf_pkg::EDGE_LAST) || (first_ff && 1'b0);
   assign cell_update     = update_ff;
   assign pass_timestep   = global_ff;

endmodule
`default_nettype wire

FILE: design/uaf_ctrl.sv
// Controller state machine sequencing one edge through the datapath.
`default_nettype none
module uaf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic [1:0]        req_edge,
   input  wire logic              out_free,
   input  wire uaf_pkg::stat_type stat,
   output logic                   req_tready,
   output uaf_pkg::cmd_type       cmd
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'h0001,
      S_MULX  = 13'h0002,
      S_MULY  = 13'h0004,
      S_NV    = 13'h0008,
      S_MULEF = 13'h0010,
      S_EF    = 13'h0020,
      S_MULLN = 13'h0040,
      S_ACC   = 13'h0080,
      S_RDIV  = 13'h0100,
      S_RWAIT = 13'h0200,
      S_FDIV  = 13'h0400,
      S_FWAIT = 13'h0800,
      S_OUT   = 13'h1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = uaf_pkg::MUL_VX_NX;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_edge != uaf_pkg::EDGE_SKIP) begin
               cmd.capture = 1'b1;
               state_in    = S_MULX;
            end
         end
         S_MULX: begin
            cmd.mul_en = 1'b1;
            state_in   = S_MULY;
         end
         S_MULY: begin
            cmd.mul_sel = uaf_pkg::MUL_VY_NY;
            cmd.mul_en  = 1'b1;
            cmd.psum_en = 1'b1;
            state_in    = S_NV;
         end
         S_NV: begin
            cmd.nv_en = 1'b1;
            state_in  = S_MULEF;
         end
         S_MULEF: begin
            cmd.mul_sel = uaf_pkg::MUL_UP_NV;
            cmd.mul_en  = 1'b1;
            state_in    = S_EF;
         end
         S_EF: begin
            cmd.ef_en = 1'b1;
            state_in  = S_MULLN;
         end
         S_MULLN: begin
            cmd.mul_sel = uaf_pkg::MUL_EF_LEN;
            cmd.mul_en  = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (stat.need_ratio) state_in = S_RDIV;
            else if (stat.last_edge) state_in = S_FDIV;
            else state_in = S_IDLE;
         end
         S_RDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_RWAIT;
         end
         S_RWAIT: begin
            if (stat.div_done) begin
               cmd.step_en = 1'b1;
               state_in    = stat.last_edge ? S_FDIV : S_IDLE;
            end
         end
         S_FDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_flux  = 1'b1;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            cmd.div_flux = 1'b1;
            if (stat.div_done) begin
               cmd.result_en = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

FILE: design/upwind_advection_flux_checker.sv
// Port-level checker for the upwind advection flux block and its bind.
`default_nettype none
`include "upwind_advection_flux_top_assert.svh"
module upwind_advection_flux_props (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [3:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata
);

   `UAF_ASSERT_RST(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)
   `UAF_ASSERT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `UAF_ASSERT(a_busy_after_take, clock, reset, req_tvalid && req_tready && req_tuser[1:0] != uaf_pkg::EDGE_SKIP |=> !req_tready)

endmodule

bind upwind_advection_flux_top upwind_advection_flux_props u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: dv/upwind_advection_flux_checker.sv
// Checker for the upwind flux block: watches the channels, predicts cell updates and compares.
`default_nettype none
module upwind_advection_flux_checker
   import uaf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [199:0] req_tdata,
   input  wire logic [3:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                failures,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint LIM31  = 64'h7FFF_FFFF;
   localparam longint MIN32  = -64'sh8000_0000;
   localparam longint MAX48  = 64'h7FFF_FFFF_FFFF;
   localparam longint MIN48  = -64'sh8000_0000_0000;

   typedef struct {
      logic [31:0] cell_update;
      logic [30:0] pass_timestep;
   } update_type;

   update_type  expected_updates[$];
   longint      vel_x, vel_y, huge_lim, max_lim;
   longint      flux_acc, cell_lim, pass_lim;

   function automatic longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   task automatic predict_edge(input logic [199:0] d, input logic [3:0] u);
      logic [1:0] edge_idx;
      longint     near_v, far_v, nx, ny, len, area, radius, nv, ef, speed, ratio;
      longint     mag, q, r, m, upd;
      update_type exp_upd;
      edge_idx = u[1:0];
      near_v   = longint'($signed(d[31:0]));
      far_v    = longint'($signed(d[63:32]));
      nx       = longint'($signed(d[81:64]));
      ny       = longint'($signed(d[99:82]));
      len      = longint'(d[130:100]);
      area     = longint'(d[161:131]);
      radius   = longint'(d[192:162]);
      if (edge_idx == EDGE_SKIP) return;
      if (u[2]) pass_lim = max_lim;
      if (edge_idx == EDGE_FIRST) begin
         flux_acc = 0;
         cell_lim = huge_lim;
      end
      nv = clip((vel_x * nx + vel_y * ny) >>> FRAC_BITS, MIN32, LIM31);
      ef = clip(((nv < 0 ? far_v : near_v) * nv) >>> FRAC_BITS, MIN32, LIM31);
      flux_acc = clip(flux_acc - ((ef * len) >>> FRAC_BITS), MIN48, MAX48);
      speed = nv < 0 ? -nv : nv;
      if (u[3] && speed != 0) begin
         ratio = (radius <<< FRAC_BITS) / speed;
         if (ratio > LIM31) ratio = LIM31;
         if (ratio < cell_lim) cell_lim = ratio;
      end
      if (edge_idx != EDGE_LAST) return;
      mag = flux_acc < 0 ? -flux_acc : flux_acc;
      if (mag == 0) begin
         upd = 0;
      end else if (area == 0) begin
         upd = flux_acc < 0 ? MIN32 : LIM31;
      end else begin
         q = mag / area;
         r = mag % area;
         if (q > ((64'd1 << 31) >> FRAC_BITS)) begin
            upd = flux_acc < 0 ? MIN32 : LIM31;
         end else begin
            m = (q <<< FRAC_BITS) + ((r <<< FRAC_BITS) / area);
            upd = clip(flux_acc < 0 ? -m : m, MIN32, LIM31);
         end
      end
      if (cell_lim < pass_lim) pass_lim = cell_lim;
      exp_upd.cell_update   = upd[31:0];
      exp_upd.pass_timestep = pass_lim[30:0];
      expected_updates.push_back(exp_upd);
   endtask

   always @(posedge clock) begin
      update_type exp_upd;
      if (reset) begin
         vel_x = 0;
         vel_y = 0;
         huge_lim = LIM31;
         max_lim = LIM31;
         flux_acc = 0;
         cell_lim = 0;
         pass_lim = LIM31;
         expected_updates.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_VELOCITY_X: vel_x = longint'($signed(csr_pwdata));
               REG_VELOCITY_Y: vel_y = longint'($signed(csr_pwdata));
               REG_HUGE_STEP:  huge_lim = longint'(csr_pwdata[30:0]);
               REG_MAX_STEP:   max_lim = longint'(csr_pwdata[30:0]);
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               $error("unexpected result %h", rsp_tdata);
               failures++;
            end else begin
               exp_upd = expected_updates.pop_front();
               if (rsp_tdata[31:0] !== exp_upd.cell_update) begin
                  $error("cell_update expected %h actual %h",
                         exp_upd.cell_update, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[62:32] !== exp_upd.pass_timestep) begin
                  $error("pass_timestep expected %h actual %h",
                         exp_upd.pass_timestep, rsp_tdata[62:32]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_edge(req_tdata, req_tuser);
      end
      pending = expected_updates.size();
   end

   initial begin
      failures = 0;
      pending  = 0;
   end

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench top for the upwind flux block: stimulus, register phases, idling and verdict.
`default_nettype none
module tb;
   import uaf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [199:0] req_tdata;   // near, far, normal_x, normal_y, length, area, radius
   logic [3:0]   req_tuser;   // edge_index, first_of_pass, full_cell
   logic         rsp_tvalid, rsp_tready;
   logic [63:0]  rsp_tdata;   // cell_update, pass_timestep
   logic         csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   int           failures, pending, idle_mode;

   upwind_advection_flux_top dut (.*);

   upwind_advection_flux_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      case (idle_mode)
         2:       rsp_tready <= $urandom_range(0, 99) >= 46;
         3:       rsp_tready <= $urandom_range(0, 99) >= 7;
         default: rsp_tready <= 1'b1;
      endcase
   end

   function automatic logic [31:0] pick_s32();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'd0;
         3:       return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_u31();
      case ($urandom_range(0, 5))
         0:       return 31'd0;
         1:       return 31'h7FFF_FFFF;
         2:       return 31'($urandom_range(1, 1 << 18));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [17:0] pick_normal();
      case ($urandom_range(0, 7))
         0:       return 18'd0;
         1:       return 18'd65536;
         2:       return -18'sd65536;
         3:       return 18'($urandom);
         default: return 18'($signed($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic logic [199:0] pack_edge(logic [31:0] nr, logic [31:0] fr,
         logic [17:0] nx, logic [17:0] ny, logic [30:0] len, logic [30:0] area,
         logic [30:0] rad);
      return {7'd0, rad, area, len, ny, nx, fr, nr};
   endfunction

   task automatic send_edge(input logic [199:0] d, input logic [1:0] edge_idx,
                            input logic first, input logic full);
      if ((idle_mode == 1 && $urandom_range(0, 99) < 46) ||
          (idle_mode == 3 && $urandom_range(0, 99) < 7)) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= {full, first, edge_idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input logic [1:0] edge_idx, input logic first);
      send_edge(pack_edge(pick_s32(), pick_s32(), pick_normal(), pick_normal(),
                          pick_u31(), pick_u31(), pick_u31()),
                edge_idx, first, $urandom_range(0, 3) != 0);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_regs(input logic [31:0] vx, input logic [31:0] vy,
                           input logic [30:0] huge_v, input logic [30:0] max_v);
      csr_write(REG_VELOCITY_X, vx);
      csr_write(REG_VELOCITY_Y, vy);
      csr_write(REG_HUGE_STEP, {1'b0, huge_v});
      csr_write(REG_MAX_STEP, {1'b0, max_v});
   endtask

   initial begin
      logic [1:0] e;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_mode = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero velocity straight after reset
      send_edge(pack_edge(32'd65536, 32'd0, 18'd65536, 18'd0, 31'd65536, 31'd65536,
                          31'd65536), EDGE_FIRST, 1'b1, 1'b1);
      send_edge(pack_edge(32'd1, 32'd2, 18'd0, 18'd65536, 31'd1, 31'd1, 31'd1),
                2'd1, 1'b0, 1'b1);
      send_edge(pack_edge(32'd3, 32'd4, -18'sd65536, 18'd0, 31'd1, 31'd1, 31'd1),
                EDGE_LAST, 1'b0, 1'b1);
      drain();

      set_regs(32'd65536, -32'sd32768, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      // upwind both ways, extremes of values, zero area, zero speed
      send_edge(pack_edge(32'h7FFF_FFFF, 32'h8000_0000, 18'd65536, 18'd0,
                          31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF), EDGE_FIRST, 1'b1, 1'b1);
      send_edge(pack_edge(32'h7FFF_FFFF, 32'h8000_0000, -18'sd65536, 18'd0,
                          31'h7FFF_FFFF, 31'd0, 31'd0), 2'd1, 1'b0, 1'b1);
      send_edge(pack_edge(32'd100, 32'd200, 18'd0, 18'd0, 31'd65536, 31'd0,
                          31'd12345), EDGE_LAST, 1'b0, 1'b1);
      send_edge(pack_edge(32'hFFFF_0000, 32'd5, 18'd0, -18'sd65536, 31'd65536, 31'd0,
                          31'd1), EDGE_FIRST, 1'b0, 1'b0);
      send_edge(pack_edge(32'd0, 32'd0, 18'd0, 18'd0, 31'd0, 31'd0, 31'd0),
                2'd1, 1'b0, 1'b0);
      send_edge(pack_edge(32'd0, 32'd0, 18'd0, 18'd0, 31'd0, 31'd0, 31'd0),
                EDGE_LAST, 1'b0, 1'b0);
      // skipped edge, then edges out of order onto the current cell
      send_edge(pack_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h3FFFF, 18'h20000,
                          31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
                EDGE_SKIP, 1'b1, 1'b1);
      send_edge(pack_edge(32'd65536, 32'd0, 18'd65536, 18'd65536, 31'd131072,
                          31'd1, 31'd65536), EDGE_LAST, 1'b0, 1'b1);
      send_edge(pack_edge(32'd65536, 32'd0, 18'd65536, 18'd65536, 31'd131072,
                          31'h7FFF_FFFF, 31'd65536), EDGE_LAST, 1'b1, 1'b1);
      send_edge(pack_edge(32'd7, 32'd9, 18'd65536, 18'd0, 31'd65536, 31'd65536,
                          31'd65536), 2'd1, 1'b0, 1'b1);
      send_edge(pack_edge(32'd7, 32'd9, 18'd65536, 18'd0, 31'd65536, 31'd65536,
                          31'd65536), EDGE_LAST, 1'b0, 1'b1);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_regs(32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0);
            1: set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
            2: set_regs(32'd0, 32'd0, 31'h7FFF_FFFF, 31'd65536);
            default: set_regs(pick_s32(), pick_s32(), pick_u31(), pick_u31());
         endcase
         idle_mode = phase % 4;
         for (int n = 0; n < 150; ) begin
            if ($urandom_range(0, 9) == 0) begin
               e = 2'($urandom);
               send_random(e, $urandom_range(0, 3) == 0);
               n++;
            end else begin
               send_random(EDGE_FIRST, $urandom_range(0, 7) == 0);
               send_random(2'd1, 1'b0);
               send_random(EDGE_LAST, 1'b0);
               n += 3;
            end
            // hold until every pending result is back
            if (n >= 75 && n < 78) drain();
         end
         drain();
      end

      idle_mode = 0;
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
